// ----- rtl/core/cbpg_pkg.sv -----
`timescale 1ns / 1ps

package cbpg_pkg;

  // default capacity of the box store
  localparam int MAX_BOXES_DEF = 32;

  // field widths
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 12;
  localparam int DIAG_W      = 17;
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int MIN_W       = 6;
  localparam int GROUP_W     = 5;
  localparam int MEMBER_W    = 5;

  // results per run are capped
  localparam int RESULT_CAP = 32;
  localparam int RES_CNT_W  = 6;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_MULTIPLE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_CHANGE_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_CHANGE_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_CHANGE_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_GROUP_SIZE      = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] DISTANCE_MULTIPLE_RST   = 12'd1280;
  localparam logic [CFG_W-1:0] AREA_CHANGE_LIMIT_RST   = 12'd128;
  localparam logic [CFG_W-1:0] WIDTH_CHANGE_LIMIT_RST  = 12'd205;
  localparam logic [CFG_W-1:0] HEIGHT_CHANGE_LIMIT_RST = 12'd51;
  localparam logic [MIN_W-1:0] MIN_GROUP_SIZE_RST      = 6'd3;

  // one stored box
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]  wd;
    logic [SIZE_W-1:0]  ht;
    logic [DIAG_W-1:0]  diag;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic clear_marks;
    logic seed_rd;
    logic clear_cand;
    logic pair_rd;
    logic pair_qual;
    logic mark;
    logic emit;
    logic gend;
    logic flush;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_taken;
    logic cand_at;
    logic seed_ready;
    logic hit;
    logic pair_busy;
    logic slot_free;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/cbpg_ram.sv -----
`timescale 1ns / 1ps

module cbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/cbpg_dp.sv -----
`timescale 1ns / 1ps

module cbpg_dp #(
  parameter int MAX_BOXES = cbpg_pkg::MAX_BOXES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [cbpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cbpg_pkg::CFG_W-1:0]          cfg_data,
  output logic [cbpg_pkg::MIN_W-1:0]          min_group_size,
  // incoming box
  input  logic [cbpg_pkg::COORD_W-1:0]        center_x,
  input  logic [cbpg_pkg::COORD_W-1:0]        center_y,
  input  logic [cbpg_pkg::SIZE_W-1:0]         box_width,
  input  logic [cbpg_pkg::SIZE_W-1:0]         box_height,
  input  logic [cbpg_pkg::DIAG_W-1:0]         diagonal_length,
  // control
  input  cbpg_pkg::dp_cmd_t                   cmd,
  input  logic [$clog2(MAX_BOXES)-1:0]        wr_addr,
  input  logic [$clog2(MAX_BOXES)-1:0]        rd_addr,
  input  logic [$clog2(MAX_BOXES)-1:0]        sel_idx,
  input  logic [cbpg_pkg::GROUP_W-1:0]        grp,
  output cbpg_pkg::dp_sts_t                   sts,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbpg_pkg::GROUP_W-1:0]        group_number,
  output logic [cbpg_pkg::MEMBER_W-1:0]       member_index,
  output logic                                member_valid,
  output logic                                group_end,
  output logic                                run_end
);

  localparam int IW      = $clog2(MAX_BOXES);
  localparam int IXW     = IW + cbpg_pkg::MEMBER_W;
  localparam int REACH_W = cbpg_pkg::DIAG_W + cbpg_pkg::CFG_W;
  localparam int RL_W    = 15;
  localparam int RH_W    = REACH_W - RL_W;
  localparam int SQ_W    = 2 * REACH_W;
  localparam int AREA_W  = 2 * cbpg_pkg::SIZE_W;
  localparam int SQD_W   = 2 * cbpg_pkg::COORD_W;
  localparam int DIST_W  = SQD_W + 1;
  localparam int ARHS_W  = AREA_W + cbpg_pkg::CFG_W;
  localparam int WRHS_W  = cbpg_pkg::SIZE_W + cbpg_pkg::CFG_W;
  localparam int FRAC_W  = 8;

  function automatic logic [cbpg_pkg::SIZE_W-1:0] absdiff12(
    input logic [cbpg_pkg::SIZE_W-1:0] a,
    input logic [cbpg_pkg::SIZE_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration registers
  logic [cbpg_pkg::CFG_W-1:0] dist_mult;
  logic [cbpg_pkg::CFG_W-1:0] area_lim;
  logic [cbpg_pkg::CFG_W-1:0] width_lim;
  logic [cbpg_pkg::CFG_W-1:0] height_lim;
  logic [cbpg_pkg::MIN_W-1:0] min_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_mult  <= cbpg_pkg::DISTANCE_MULTIPLE_RST;
      area_lim   <= cbpg_pkg::AREA_CHANGE_LIMIT_RST;
      width_lim  <= cbpg_pkg::WIDTH_CHANGE_LIMIT_RST;
      height_lim <= cbpg_pkg::HEIGHT_CHANGE_LIMIT_RST;
      min_size   <= cbpg_pkg::MIN_GROUP_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cbpg_pkg::REG_DISTANCE_MULTIPLE:   dist_mult  <= cfg_data;
        cbpg_pkg::REG_AREA_CHANGE_LIMIT:   area_lim   <= cfg_data;
        cbpg_pkg::REG_WIDTH_CHANGE_LIMIT:  width_lim  <= cfg_data;
        cbpg_pkg::REG_HEIGHT_CHANGE_LIMIT: height_lim <= cfg_data;
        cbpg_pkg::REG_MIN_GROUP_SIZE:      min_size   <= cfg_data[cbpg_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign min_group_size = min_size;

  // box store
  cbpg_pkg::box_t               wr_box;
  cbpg_pkg::box_t               rd_box;
  logic [$bits(cbpg_pkg::box_t)-1:0] rd_word;

  assign wr_box = {center_x, center_y, box_width, box_height, diagonal_length};
  assign rd_box = rd_word;

  cbpg_ram #(
    .WIDTH ($bits(cbpg_pkg::box_t)),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_box),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // seed preparation: latch seed, reach, then reach squared in three partial products
  logic                        seed_v0, seed_v1, seed_v2, seed_v3;
  logic [cbpg_pkg::COORD_W-1:0] seed_x, seed_y;
  logic [cbpg_pkg::SIZE_W-1:0]  seed_w, seed_h;
  logic [REACH_W-1:0]           reach;
  logic [AREA_W-1:0]            area_a;
  logic [2*RH_W-1:0]            p_hh;
  logic [RH_W+RL_W-1:0]         p_hl;
  logic [2*RL_W-1:0]            p_ll;
  logic [SQ_W-1:0]              reach_sq;
  logic [RH_W-1:0]              reach_hi;
  logic [RL_W-1:0]              reach_lo;

  assign reach_hi = reach[REACH_W-1:RL_W];
  assign reach_lo = reach[RL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_v0 <= 1'b0;
      seed_v1 <= 1'b0;
      seed_v2 <= 1'b0;
      seed_v3 <= 1'b0;
    end else begin
      seed_v0 <= cmd.seed_rd;
      seed_v1 <= seed_v0;
      seed_v2 <= seed_v1;
      seed_v3 <= seed_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (seed_v0) begin
      seed_x <= rd_box.cx;
      seed_y <= rd_box.cy;
      seed_w <= rd_box.wd;
      seed_h <= rd_box.ht;
      reach  <= REACH_W'(rd_box.diag) * REACH_W'(dist_mult);
      area_a <= AREA_W'(rd_box.wd) * AREA_W'(rd_box.ht);
    end
    if (seed_v1) begin
      p_hh <= (2*RH_W)'(reach_hi) * (2*RH_W)'(reach_hi);
      p_hl <= (RH_W+RL_W)'(reach_hi) * (RH_W+RL_W)'(reach_lo);
      p_ll <= (2*RL_W)'(reach_lo) * (2*RL_W)'(reach_lo);
    end
    if (seed_v2) begin
      reach_sq <= (SQ_W'(p_hh) << (2*RL_W)) + (SQ_W'(p_hl) << (RL_W+1)) + SQ_W'(p_ll);
    end
  end

  // pair test pipeline, stage 1: differences and size products
  logic          p1_v, p1_q, p2_v, p2_q, p3_v, p3_q, hit_q;
  logic [IW-1:0] p1_idx, p2_idx, p3_idx;

  logic [cbpg_pkg::COORD_W-1:0] s2_dx, s2_dy;
  logic [cbpg_pkg::SIZE_W-1:0]  s2_dw, s2_dh;
  logic [AREA_W-1:0]            s2_area_b;
  logic [WRHS_W-1:0]            s2_wrhs, s2_hrhs;

  logic [SQD_W-1:0]             s3_dx2, s3_dy2;
  logic [AREA_W-1:0]            s3_da;
  logic [ARHS_W-1:0]            s3_arhs;
  logic                         s3_w_ok, s3_h_ok;

  logic [DIST_W-1:0]            dist_sum;
  logic                         d_ok, a_ok, hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p1_q  <= 1'b0;
      p2_q  <= 1'b0;
      p3_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      p1_v  <= cmd.pair_rd;
      p1_q  <= cmd.pair_qual;
      p2_v  <= p1_v;
      p2_q  <= p1_q;
      p3_v  <= p2_v;
      p3_q  <= p2_q;
      hit_q <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= rd_addr;
    p2_idx <= p1_idx;
    p3_idx <= p2_idx;

    // stage 1
    s2_dx     <= absdiff12(seed_x, rd_box.cx);
    s2_dy     <= absdiff12(seed_y, rd_box.cy);
    s2_dw     <= absdiff12(seed_w, rd_box.wd);
    s2_dh     <= absdiff12(seed_h, rd_box.ht);
    s2_area_b <= AREA_W'(rd_box.wd) * AREA_W'(rd_box.ht);
    s2_wrhs   <= WRHS_W'(width_lim) * WRHS_W'(rd_box.wd);
    s2_hrhs   <= WRHS_W'(height_lim) * WRHS_W'(rd_box.ht);

    // stage 2
    s3_dx2  <= SQD_W'(s2_dx) * SQD_W'(s2_dx);
    s3_dy2  <= SQD_W'(s2_dy) * SQD_W'(s2_dy);
    s3_da   <= (area_a > s2_area_b) ? (area_a - s2_area_b) : (s2_area_b - area_a);
    s3_arhs <= ARHS_W'(area_lim) * ARHS_W'(s2_area_b);
    s3_w_ok <= WRHS_W'({s2_dw, {FRAC_W{1'b0}}}) < s2_wrhs;
    s3_h_ok <= WRHS_W'({s2_dh, {FRAC_W{1'b0}}}) < s2_hrhs;
  end

  // stage 3: distance and area compares
  assign dist_sum = DIST_W'(s3_dx2) + DIST_W'(s3_dy2);
  assign d_ok     = SQ_W'({dist_sum, 24'b0}) < reach_sq;
  assign a_ok     = ARHS_W'({s3_da, {FRAC_W{1'b0}}}) < s3_arhs;
  assign hit_next = p3_v && p3_q && d_ok && a_ok && s3_w_ok && s3_h_ok;

  // candidate and taken marks
  logic [MAX_BOXES-1:0] cand;
  logic [MAX_BOXES-1:0] taken;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_cand) begin
      cand <= '0;
    end else if (hit_next) begin
      cand[p3_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_marks) begin
      taken <= '0;
    end else if (cmd.mark) begin
      taken[sel_idx] <= 1'b1;
    end
  end

  // output stage: pending member plus output register
  logic                          pend_v;
  logic [cbpg_pkg::GROUP_W-1:0]  pend_grp;
  logic [cbpg_pkg::MEMBER_W-1:0] pend_idx;
  logic                          pend_gend;
  logic [IXW-1:0]                sel_wide;
  logic                          out_free;

  assign sel_wide = IXW'(sel_idx);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_v <= 1'b1;
      if (pend_v) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (cmd.flush) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (pend_v) begin
        group_number <= pend_grp;
        member_index <= pend_idx;
        member_valid <= 1'b1;
        group_end    <= pend_gend;
        run_end      <= 1'b0;
      end
      pend_grp  <= grp;
      pend_idx  <= sel_wide[cbpg_pkg::MEMBER_W-1:0];
      pend_gend <= cmd.gend;
    end else if (cmd.flush) begin
      if (pend_v) begin
        group_number <= pend_grp;
        member_index <= pend_idx;
        member_valid <= 1'b1;
      end else begin
        group_number <= '0;
        member_index <= '0;
        member_valid <= 1'b0;
      end
      group_end <= pend_v;
      run_end   <= 1'b1;
    end
  end

  // status back to the controller
  assign sts.rd_taken   = taken[rd_addr];
  assign sts.cand_at    = cand[sel_idx];
  assign sts.seed_ready = seed_v3;
  assign sts.hit        = hit_q;
  assign sts.pair_busy  = p1_v || p2_v || p3_v || hit_q;
  assign sts.slot_free  = !pend_v || out_free;
  assign sts.out_free   = out_free;

endmodule

// ----- rtl/core/cbpg_ctrl.sv -----
`timescale 1ns / 1ps

module cbpg_ctrl #(
  parameter int MAX_BOXES = cbpg_pkg::MAX_BOXES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               final_box,
  input  logic [cbpg_pkg::MIN_W-1:0]         min_group_size,
  input  cbpg_pkg::dp_sts_t                  sts,
  output cbpg_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(MAX_BOXES)-1:0]       wr_addr,
  output logic [$clog2(MAX_BOXES)-1:0]       rd_addr,
  output logic [$clog2(MAX_BOXES)-1:0]       sel_idx,
  output logic [cbpg_pkg::GROUP_W-1:0]       grp
);

  localparam int IW    = $clog2(MAX_BOXES);
  localparam int CW    = $clog2(MAX_BOXES + 1);
  localparam int CMP_W = (CW > cbpg_pkg::MIN_W) ? CW : cbpg_pkg::MIN_W;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SEED      = 9'b000000010,
    S_SEED_WAIT = 9'b000000100,
    S_SWEEP     = 9'b000001000,
    S_DRAIN     = 9'b000010000,
    S_DECIDE    = 9'b000100000,
    S_EMIT_SEED = 9'b001000000,
    S_EMIT_SCAN = 9'b010000000,
    S_FLUSH     = 9'b100000000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  logic [CW-1:0]                  box_count, box_count_next;
  logic [CW-1:0]                  seed_i, seed_i_next;
  logic [CW-1:0]                  sweep_j, sweep_j_next;
  logic [CW-1:0]                  scan_p, scan_p_next;
  logic [CW-1:0]                  member_cnt, member_cnt_next;
  logic [CW-1:0]                  remain, remain_next;
  logic [cbpg_pkg::RES_CNT_W-1:0] result_cnt, result_cnt_next;
  logic [cbpg_pkg::GROUP_W-1:0]   group_num, group_num_next;

  logic accept;
  logic need_out;
  logic take;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_addr  = box_count[IW-1:0];
  assign grp      = group_num;
  assign need_out = result_cnt < cbpg_pkg::RES_CNT_W'(cbpg_pkg::RESULT_CAP);

  // a member of the current group is handled this cycle
  assign take = ((state == S_EMIT_SEED) || ((state == S_EMIT_SCAN) && sts.cand_at))
                && (!need_out || sts.slot_free);

  // next state and commands
  always_comb begin
    state_next      = state;
    box_count_next  = box_count;
    seed_i_next     = seed_i;
    sweep_j_next    = sweep_j;
    scan_p_next     = scan_p;
    member_cnt_next = member_cnt;
    remain_next     = remain;
    result_cnt_next = result_cnt;
    group_num_next  = group_num;
    cmd             = '0;
    rd_addr         = seed_i[IW-1:0];
    sel_idx         = seed_i[IW-1:0];

    // near boxes found by the pair pipeline
    if (sts.hit) begin
      member_cnt_next = member_cnt + CW'(1);
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (box_count < CW'(MAX_BOXES)) begin
            cmd.load_wr    = 1'b1;
            box_count_next = box_count + CW'(1);
          end
          if (final_box) begin
            cmd.clear_marks = 1'b1;
            group_num_next  = '0;
            result_cnt_next = '0;
            seed_i_next     = '0;
            state_next      = S_SEED;
          end
        end
      end
      S_SEED: begin
        if (seed_i >= box_count) begin
          state_next = S_FLUSH;
        end else if (sts.rd_taken) begin
          seed_i_next = seed_i + CW'(1);
        end else begin
          cmd.seed_rd    = 1'b1;
          cmd.clear_cand = 1'b1;
          state_next     = S_SEED_WAIT;
        end
      end
      S_SEED_WAIT: begin
        if (sts.seed_ready) begin
          sweep_j_next    = '0;
          member_cnt_next = CW'(1);
          state_next      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        rd_addr       = sweep_j[IW-1:0];
        cmd.pair_rd   = 1'b1;
        cmd.pair_qual = !sts.rd_taken && (sweep_j != seed_i);
        if (sweep_j == box_count - CW'(1)) begin
          state_next = S_DRAIN;
        end else begin
          sweep_j_next = sweep_j + CW'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.pair_busy) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (CMP_W'(member_cnt) >= CMP_W'(min_group_size)) begin
          remain_next = member_cnt;
          state_next  = S_EMIT_SEED;
        end else begin
          seed_i_next = seed_i + CW'(1);
          state_next  = S_SEED;
        end
      end
      S_EMIT_SEED: begin
        sel_idx = seed_i[IW-1:0];
        if (take) begin
          scan_p_next = '0;
        end
      end
      S_EMIT_SCAN: begin
        sel_idx = scan_p[IW-1:0];
        if (!sts.cand_at || take) begin
          scan_p_next = scan_p + CW'(1);
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush      = 1'b1;
          box_count_next = '0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // mark the member, emit it while under the result cap
    if (take) begin
      cmd.mark    = 1'b1;
      cmd.gend    = (remain == CW'(1));
      remain_next = remain - CW'(1);
      if (need_out) begin
        cmd.emit        = 1'b1;
        result_cnt_next = result_cnt + cbpg_pkg::RES_CNT_W'(1);
      end
      if (remain == CW'(1)) begin
        group_num_next = group_num + cbpg_pkg::GROUP_W'(1);
        seed_i_next    = seed_i + CW'(1);
        state_next     = S_SEED;
      end else begin
        state_next = S_EMIT_SCAN;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      box_count  <= '0;
      seed_i     <= '0;
      sweep_j    <= '0;
      scan_p     <= '0;
      member_cnt <= '0;
      remain     <= '0;
      result_cnt <= '0;
      group_num  <= '0;
    end else begin
      state      <= state_next;
      box_count  <= box_count_next;
      seed_i     <= seed_i_next;
      sweep_j    <= sweep_j_next;
      scan_p     <= scan_p_next;
      member_cnt <= member_cnt_next;
      remain     <= remain_next;
      result_cnt <= result_cnt_next;
      group_num  <= group_num_next;
    end
  end

endmodule

// ----- rtl/core/char_box_proximity_grouping_unit.sv -----
`timescale 1ns / 1ps
// Boxes load one per cycle into the box store while the unit is idle; a box without
// final_box gives no result. A final box starts a run over the N stored boxes: a marked
// seed is skipped; an unmarked seed is checked, prepared, swept against every stored box,
// drained and decided, its members walked when a group forms; output stalls slow the run.
// Results leave through a pending stage and an output register, one per cycle at most.
// Synchronous reset clears the controller, marks and counters and presets the configuration.

module char_box_proximity_grouping_unit #(
  parameter int MAX_BOXES = cbpg_pkg::MAX_BOXES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [cbpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cbpg_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cbpg_pkg::COORD_W-1:0]       center_x,
  input  logic [cbpg_pkg::COORD_W-1:0]       center_y,
  input  logic [cbpg_pkg::SIZE_W-1:0]        box_width,
  input  logic [cbpg_pkg::SIZE_W-1:0]        box_height,
  input  logic [cbpg_pkg::DIAG_W-1:0]        diagonal_length,
  input  logic                               final_box,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cbpg_pkg::GROUP_W-1:0]       group_number,
  output logic [cbpg_pkg::MEMBER_W-1:0]      member_index,
  output logic                               member_valid,
  output logic                               group_end,
  output logic                               run_end
);

  cbpg_pkg::dp_cmd_t                 cmd;
  cbpg_pkg::dp_sts_t                 sts;
  logic [$clog2(MAX_BOXES)-1:0]      wr_addr;
  logic [$clog2(MAX_BOXES)-1:0]      rd_addr;
  logic [$clog2(MAX_BOXES)-1:0]      sel_idx;
  logic [cbpg_pkg::GROUP_W-1:0]      grp;
  logic [cbpg_pkg::MIN_W-1:0]        min_group_size;

  // grouping sequencer
  cbpg_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .final_box      (final_box),
    .min_group_size (min_group_size),
    .sts            (sts),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .sel_idx        (sel_idx),
    .grp            (grp)
  );

  // configuration, box store, pair tests, marks and result registers
  cbpg_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .min_group_size  (min_group_size),
    .center_x        (center_x),
    .center_y        (center_y),
    .box_width       (box_width),
    .box_height      (box_height),
    .diagonal_length (diagonal_length),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .sel_idx         (sel_idx),
    .grp             (grp),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .group_number    (group_number),
    .member_index    (member_index),
    .member_valid    (member_valid),
    .group_end       (group_end),
    .run_end         (run_end)
  );

endmodule

// ----- dv/tb_char_box_proximity_grouping_unit.sv -----
`timescale 1ns / 1ps

module tb_char_box_proximity_grouping_unit;
  import cbpg_pkg::*;

  localparam int BOX_CAP = MAX_BOXES_DEF;
  localparam int ITEM_TARGET = 360;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_W-1:0] LIMIT_MAX = 12'd4095;

  // one member item as the block reports it
  typedef struct packed {
    logic [GROUP_W-1:0]  grp;
    logic [MEMBER_W-1:0] idx;
    logic                valid;
    logic                gend;
    logic                rend;
  } member_item_t;

  // box store, settings and expected member items of the grouping runs
  class grouping_scoreboard;
    logic [CFG_W-1:0] dist_mult;
    logic [CFG_W-1:0] area_lim;
    logic [CFG_W-1:0] width_lim;
    logic [CFG_W-1:0] height_lim;
    logic [MIN_W-1:0] min_size;
    box_t             store[BOX_CAP];
    int               stored;
    member_item_t     expected_q[$];
    int               errors;

    function new();
      dist_mult  = DISTANCE_MULTIPLE_RST;
      area_lim   = AREA_CHANGE_LIMIT_RST;
      width_lim  = WIDTH_CHANGE_LIMIT_RST;
      height_lim = HEIGHT_CHANGE_LIMIT_RST;
      min_size   = MIN_GROUP_SIZE_RST;
      stored     = 0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DISTANCE_MULTIPLE:   dist_mult = data;
        REG_AREA_CHANGE_LIMIT:   area_lim = data;
        REG_WIDTH_CHANGE_LIMIT:  width_lim = data;
        REG_HEIGHT_CHANGE_LIMIT: height_lim = data;
        REG_MIN_GROUP_SIZE:      min_size = data[MIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [63:0] abs_gap(logic [63:0] p, logic [63:0] q);
      return (p > q) ? p - q : q - p;
    endfunction

    // all four nearness tests of seed a against box b
    function bit near(int a, int b);
      logic [63:0] dx, dy, reach, area_a, area_b;
      dx = abs_gap(64'(store[a].cx), 64'(store[b].cx));
      dy = abs_gap(64'(store[a].cy), 64'(store[b].cy));
      reach = 64'(store[a].diag) * 64'(dist_mult);
      area_a = 64'(store[a].wd) * 64'(store[a].ht);
      area_b = 64'(store[b].wd) * 64'(store[b].ht);
      if (((dx * dx + dy * dy) << 24) >= reach * reach) return 1'b0;
      if (abs_gap(area_a, area_b) * 256 >= 64'(area_lim) * area_b) return 1'b0;
      if (abs_gap(64'(store[a].wd), 64'(store[b].wd)) * 256 >= 64'(width_lim) * 64'(store[b].wd))
        return 1'b0;
      if (abs_gap(64'(store[a].ht), 64'(store[b].ht)) * 256 >= 64'(height_lim) * 64'(store[b].ht))
        return 1'b0;
      return 1'b1;
    endfunction

    // greedy grouping over the stored set
    function void run_groups();
      bit           taken[BOX_CAP];
      int           members[$];
      member_item_t run_q[$];
      member_item_t r;
      logic [GROUP_W-1:0] grp_no;
      int           i, j;
      grp_no = '0;
      foreach (taken[t]) taken[t] = 1'b0;
      for (i = 0; i < stored; i++) begin
        if (taken[i]) continue;
        members.delete();
        members = {members, i};
        for (j = 0; j < stored; j++) begin
          if (!taken[j] && j != i && near(i, j)) members = {members, j};
        end
        if (members.size() < min_size) continue;
        foreach (members[m]) begin
          taken[members[m]] = 1'b1;
          if (run_q.size() < RESULT_CAP) begin
            r.grp   = grp_no;
            r.idx   = MEMBER_W'(members[m]);
            r.valid = 1'b1;
            r.gend  = (m == members.size() - 1);
            r.rend  = 1'b0;
            run_q = {run_q, r};
          end
        end
        grp_no++;
      end
      // no group: one empty item closes the run
      if (run_q.size() == 0) begin
        r = '0;
        r.rend = 1'b1;
        run_q = {run_q, r};
      end else begin
        run_q[run_q.size() - 1].gend = 1'b1;
        run_q[run_q.size() - 1].rend = 1'b1;
      end
      expected_q = {expected_q, run_q};
    endfunction

    // accepted box: store unless full, final box runs the grouping
    function void note_box(box_t b, logic fin);
      if (stored < BOX_CAP) begin
        store[stored] = b;
        stored++;
      end
      if (fin) begin
        run_groups();
        stored = 0;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(member_item_t got);
      member_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item group %0d member %0d", got.grp, got.idx));
        return;
      end
      want = expected_q.pop_front();
      if (got.grp !== want.grp)
        report_mismatch($sformatf("group_number %0d, want %0d", got.grp, want.grp));
      if (got.idx !== want.idx)
        report_mismatch($sformatf("member_index %0d, want %0d", got.idx, want.idx));
      if (got.valid !== want.valid)
        report_mismatch($sformatf("member_valid %0b, want %0b", got.valid, want.valid));
      if (got.gend !== want.gend)
        report_mismatch($sformatf("group_end %0b, want %0b", got.gend, want.gend));
      if (got.rend !== want.rend)
        report_mismatch($sformatf("run_end %0b, want %0b", got.rend, want.rend));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [COORD_W-1:0]     center_x;
  logic [COORD_W-1:0]     center_y;
  logic [SIZE_W-1:0]      box_width;
  logic [SIZE_W-1:0]      box_height;
  logic [DIAG_W-1:0]      diagonal_length;
  logic                   final_box;
  logic                   out_valid;
  logic                   out_ready;
  logic [GROUP_W-1:0]     group_number;
  logic [MEMBER_W-1:0]    member_index;
  logic                   member_valid;
  logic                   group_end;
  logic                   run_end;

  grouping_scoreboard sb;
  box_t set_q[$];
  int   items_sent = 0;
  bit   steady = 1'b0;
  bit   hold_pending = 1'b0;

  char_box_proximity_grouping_unit #(
    .MAX_BOXES(BOX_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .center_x(center_x),
    .center_y(center_y),
    .box_width(box_width),
    .box_height(box_height),
    .diagonal_length(diagonal_length),
    .final_box(final_box),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .group_number(group_number),
    .member_index(member_index),
    .member_valid(member_valid),
    .group_end(group_end),
    .run_end(run_end)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, a few long
  function int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function box_t mk_box(int cx, int cy, int w, int h, int d);
    box_t b;
    b.cx   = COORD_W'(cx);
    b.cy   = COORD_W'(cy);
    b.wd   = SIZE_W'(w);
    b.ht   = SIZE_W'(h);
    b.diag = DIAG_W'(d);
    return b;
  endfunction

  function int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(2, 12);
    if (r < 93) return $urandom_range(13, BOX_CAP - 1);
    return $urandom_range(BOX_CAP, BOX_CAP + 6);
  endfunction

  function logic [CFG_W-1:0] pick_limit(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LIMIT_MAX;
    return CFG_W'($urandom_range(lo, hi));
  endfunction

  // set of clustered boxes with some noise boxes mixed in
  function void build_set(int count);
    int   k, n, bw, bh, bx, by, w, h;
    box_t b;
    set_q.delete();
    while (set_q.size() < count) begin
      if ($urandom_range(0, 6) == 0) begin
        b = mk_box($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 4095),
                   $urandom_range(1, 4095), $urandom_range(0, 131071));
        if ($urandom_range(0, 15) == 0) b.wd = '0;
        if ($urandom_range(0, 15) == 0) b.ht = '0;
        set_q = {set_q, b};
      end else begin
        k = $urandom_range(2, 6);
        bw = $urandom_range(4, 200);
        bh = $urandom_range(8, 300);
        bx = $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
        for (n = 0; n < k && set_q.size() < count; n++) begin
          w = bw + $urandom_range(0, bw / 4);
          h = bh + $urandom_range(0, bh / 8);
          b = mk_box(clamp_coord(bx + $urandom_range(0, 4 * bh) - 2 * bh),
                     clamp_coord(by + $urandom_range(0, 2 * bh) - bh),
                     w, h, (w + h) * 12 + $urandom_range(0, 64));
          set_q = {set_q, b};
        end
      end
    end
  endfunction

  // offer one box and wait until it is taken
  task automatic send_box(box_t b, logic fin);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    center_x        <= b.cx;
    center_y        <= b.cy;
    box_width       <= b.wd;
    box_height      <= b.ht;
    diagonal_length <= b.diag;
    final_box       <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set();
    foreach (set_q[k]) send_box(set_q[k], k == set_q.size() - 1);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic program_registers(logic [CFG_W-1:0] dm, logic [CFG_W-1:0] al,
                                   logic [CFG_W-1:0] wl, logic [CFG_W-1:0] hl,
                                   logic [MIN_W-1:0] ms, bit poke_unused);
    write_reg(REG_DISTANCE_MULTIPLE, dm);
    write_reg(REG_AREA_CHANGE_LIMIT, al);
    write_reg(REG_WIDTH_CHANGE_LIMIT, wl);
    write_reg(REG_HEIGHT_CHANGE_LIMIT, hl);
    write_reg(REG_MIN_GROUP_SIZE, CFG_W'(ms));
    if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
    cfg_write <= 1'b0;
  endtask

  // wait for every expected item, then let the block settle
  task automatic wait_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected items never arrived", sb.pending()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = idle_cycles();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_box(mk_box(center_x, center_y, box_width, box_height, diagonal_length),
                    final_box);
      if (out_valid && out_ready)
        sb.check_result('{group_number, member_index, member_valid, group_end, run_end});
    end
  end

  // stimulus
  initial begin
    int phase, nsets;
    logic [MIN_W-1:0] ms;
    sb = new();
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    center_x        <= '0;
    center_y        <= '0;
    box_width       <= '0;
    box_height      <= '0;
    diagonal_length <= '0;
    final_box       <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // field extremes, two boxes only: no group
    send_box(mk_box(0, 0, 1, 1, 0), 1'b0);
    send_box(mk_box(4095, 4095, 4095, 4095, 131071), 1'b1);
    // one tight group of three
    send_box(mk_box(100, 100, 40, 60, 1154), 1'b0);
    send_box(mk_box(130, 100, 40, 60, 1154), 1'b0);
    send_box(mk_box(160, 100, 40, 60, 1154), 1'b1);
    // two groups with zero-width and zero-height boxes in between
    send_box(mk_box(1000, 2000, 20, 30, 577), 1'b0);
    send_box(mk_box(1010, 2000, 20, 30, 577), 1'b0);
    send_box(mk_box(1005, 2000, 0, 30, 577), 1'b0);
    send_box(mk_box(3000, 500, 100, 50, 1789), 1'b0);
    send_box(mk_box(1020, 2000, 20, 30, 577), 1'b0);
    send_box(mk_box(1015, 2005, 20, 0, 577), 1'b0);
    send_box(mk_box(3060, 500, 100, 50, 1789), 1'b0);
    send_box(mk_box(1030, 2000, 20, 30, 577), 1'b0);
    send_box(mk_box(3120, 500, 100, 50, 1789), 1'b1);
    // same center with zero diagonal never passes the distance test
    send_box(mk_box(500, 500, 30, 30, 0), 1'b0);
    send_box(mk_box(500, 500, 30, 30, 0), 1'b0);
    send_box(mk_box(500, 500, 30, 30, 0), 1'b1);
    // lone final box
    send_box(mk_box(2048, 2048, 64, 64, 1448), 1'b1);

    // random phases, settings changed only while idle
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case (phase)
        0: program_registers(12'd1280, 12'd128, 12'd205, 12'd51, 6'd3, 1'b1);
        1: program_registers('0, '0, '0, '0, 6'd1, 1'b0);
        2: program_registers(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 6'd32, 1'b0);
        3: program_registers(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 6'd3, 1'b1);
        4: program_registers(pick_limit(256, 2560), pick_limit(32, 512),
                             pick_limit(32, 512), pick_limit(16, 256), 6'd0, 1'b0);
        default: begin
          case ($urandom_range(0, 9))
            0: ms = 6'd32;
            1: ms = 6'd63;
            default: ms = MIN_W'($urandom_range(1, 5));
          endcase
          program_registers(pick_limit(256, 2560), pick_limit(32, 512),
                            pick_limit(32, 512), pick_limit(16, 256), ms, phase % 3 == 0);
        end
      endcase
      steady = (phase % 4 == 3);
      // receiver stalls long while sets keep coming, so the block backs up
      if (phase == 0) hold_pending = 1'b1;
      nsets = (phase == 0) ? 4 : $urandom_range(2, 4);
      repeat (nsets) begin
        build_set(pick_set_size());
        send_set();
      end
      phase++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
